[rtl/core/mtcg_pkg.sv]
package mtcg_pkg;

    localparam int NOTE_SLOTS_DEF = 128;
    localparam int ZONE_SLOTS_DEF = 32;
    localparam int FIRST_ZONE_DEF = 0;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int DIV_STEPS = 14;

    localparam logic [6:0]  BASE_NOTE_RST  = 7'd36;
    localparam logic [6:0]  TOUCH_CC_RST   = 7'd1;
    localparam logic [15:0] PULSE_TICKS_RST = 16'd10;
    localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [6:0]  CC_PEAK_RST    = 7'd127;

    localparam logic [6:0]  LEVEL_MAX   = 7'd127;
    localparam logic [7:0]  PITCH_MAX   = 8'd60;
    localparam logic [15:0] TICKS_MAX   = 16'hFFFF;
    localparam logic [7:0]  TOTAL_MAX   = 8'd255;

    localparam int PULSE_FAST = 0;
    localparam int PULSE_SLOW = 1;
    localparam int PULSE_RAND = 2;

    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_CC       = 2'd2,
        CMD_TICK     = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        REG_BASE_NOTE   = 3'd0,
        REG_TOUCH_CC    = 3'd1,
        REG_PULSE_TICKS = 3'd2,
        REG_DEBOUNCE    = 3'd3,
        REG_CC_PEAK     = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CC      = 2'd2,
        KIND_TICK    = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PRESS,
        ST_RELEASE,
        ST_CC_START,
        ST_DIV,
        ST_CC_END,
        ST_TICK,
        ST_SCAN,
        ST_SCAN_APPLY,
        ST_ZONE,
        ST_ZONE_READ,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] key;
        logic [6:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [5:0] fast_pitch;
        logic [5:0] slow_pitch;
        logic [6:0] random_level;
        logic [6:0] touch_level;
        logic       fast_gate;
        logic       slow_gate;
        logic       random_gate;
        logic       touch_gate;
    } out_item_t;

    typedef struct packed {
        logic ld_item;
        logic do_press;
        logic do_release;
        logic do_tick;
        logic cc_start;
        logic div_step;
        logic cc_end;
        logic scan_step;
        logic scan_apply;
        logic zone_eval;
        logic zone_read;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        kind_t kind;
        logic  item_ok;
        logic  press_zone;
        logic  rel_scan;
        logic  scan_done;
        logic  div_done;
        logic  zone_need_read;
        logic  out_free;
    } stat_t;

    function automatic logic [5:0] clamp_pitch(input logic signed [7:0] p);
        logic [5:0] r;
        if (p < 0)
        begin
            r = 6'd0;
        end
        else if (p > signed'(PITCH_MAX))
        begin
            r = PITCH_MAX[5:0];
        end
        else
        begin
            r = p[5:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/midi_touch_to_cv_gate_top.sv]
// Each event passes CHECK and FINISH. An ignored event passes nothing else; a tick adds
// TICK, a release with no scan RELEASE, a note-on PRESS and possibly ZONE and ZONE_READ,
// a touch control change CC_START, DIV (one quotient bit per cycle) and CC_END, and a
// release that scans held notes RELEASE, SCAN, SCAN_APPLY, ZONE and possibly ZONE_READ.
// One event at a time; the next transfer is taken once the result is registered.
// Reset clears the FSM and most datapath state; configuration registers get defaults.
module midi_touch_to_cv_gate_top #(
    parameter int NOTE_SLOTS = mtcg_pkg::NOTE_SLOTS_DEF,
    parameter int ZONE_SLOTS = mtcg_pkg::ZONE_SLOTS_DEF,
    parameter int FIRST_ZONE = mtcg_pkg::FIRST_ZONE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  mtcg_pkg::in_item_t           in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mtcg_pkg::out_item_t          out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mtcg_pkg::PADDR_W-1:0] paddr,
    input  logic [mtcg_pkg::PDATA_W-1:0] pwdata,
    output logic [mtcg_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    mtcg_pkg::ctrl_t ctrl;
    mtcg_pkg::stat_t stat;

    assign pready = 1'b1;

    mtcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    mtcg_dp #(
        .NOTE_SLOTS (NOTE_SLOTS),
        .ZONE_SLOTS (ZONE_SLOTS),
        .FIRST_ZONE (FIRST_ZONE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata)
    );

endmodule

[rtl/core/mtcg_ctrl.sv]
module mtcg_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mtcg_pkg::stat_t stat,
    output mtcg_pkg::ctrl_t ctrl
);

    mtcg_pkg::state_t state_reg;
    mtcg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtcg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtcg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mtcg_pkg::ST_CHECK;
                end
            end
            mtcg_pkg::ST_CHECK:
            begin
                if (!stat.item_ok)
                begin
                    state_next = mtcg_pkg::ST_FINISH;
                end
                else
                begin
                    case (stat.kind)
                        mtcg_pkg::KIND_PRESS:   state_next = mtcg_pkg::ST_PRESS;
                        mtcg_pkg::KIND_RELEASE: state_next = mtcg_pkg::ST_RELEASE;
                        mtcg_pkg::KIND_CC:      state_next = mtcg_pkg::ST_CC_START;
                        default:                state_next = mtcg_pkg::ST_TICK;
                    endcase
                end
            end
            mtcg_pkg::ST_PRESS:
            begin
                state_next = stat.press_zone ? mtcg_pkg::ST_ZONE : mtcg_pkg::ST_FINISH;
            end
            mtcg_pkg::ST_RELEASE:
            begin
                state_next = stat.rel_scan ? mtcg_pkg::ST_SCAN : mtcg_pkg::ST_FINISH;
            end
            mtcg_pkg::ST_CC_START:
            begin
                state_next = mtcg_pkg::ST_DIV;
            end
            mtcg_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = mtcg_pkg::ST_CC_END;
                end
            end
            mtcg_pkg::ST_CC_END:
            begin
                state_next = mtcg_pkg::ST_FINISH;
            end
            mtcg_pkg::ST_TICK:
            begin
                state_next = mtcg_pkg::ST_FINISH;
            end
            mtcg_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = mtcg_pkg::ST_SCAN_APPLY;
                end
            end
            mtcg_pkg::ST_SCAN_APPLY:
            begin
                state_next = mtcg_pkg::ST_ZONE;
            end
            mtcg_pkg::ST_ZONE:
            begin
                state_next = stat.zone_need_read ? mtcg_pkg::ST_ZONE_READ
                                                 : mtcg_pkg::ST_FINISH;
            end
            mtcg_pkg::ST_ZONE_READ:
            begin
                state_next = mtcg_pkg::ST_FINISH;
            end
            mtcg_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = mtcg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtcg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            mtcg_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.ld_item = in_valid;
            end
            mtcg_pkg::ST_PRESS:      ctrl.do_press   = 1'b1;
            mtcg_pkg::ST_RELEASE:    ctrl.do_release = 1'b1;
            mtcg_pkg::ST_CC_START:   ctrl.cc_start   = 1'b1;
            mtcg_pkg::ST_DIV:        ctrl.div_step   = 1'b1;
            mtcg_pkg::ST_CC_END:     ctrl.cc_end     = 1'b1;
            mtcg_pkg::ST_TICK:       ctrl.do_tick    = 1'b1;
            mtcg_pkg::ST_SCAN:       ctrl.scan_step  = 1'b1;
            mtcg_pkg::ST_SCAN_APPLY: ctrl.scan_apply = 1'b1;
            mtcg_pkg::ST_ZONE:       ctrl.zone_eval  = 1'b1;
            mtcg_pkg::ST_ZONE_READ:  ctrl.zone_read  = 1'b1;
            mtcg_pkg::ST_FINISH:     ctrl.out_load   = stat.out_free;
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

[rtl/core/mtcg_dp.sv]
module mtcg_dp #(
    parameter int NOTE_SLOTS = mtcg_pkg::NOTE_SLOTS_DEF,
    parameter int ZONE_SLOTS = mtcg_pkg::ZONE_SLOTS_DEF,
    parameter int FIRST_ZONE = mtcg_pkg::FIRST_ZONE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mtcg_pkg::ctrl_t              ctrl,
    output mtcg_pkg::stat_t              stat,
    input  mtcg_pkg::in_item_t           in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mtcg_pkg::out_item_t          out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mtcg_pkg::PADDR_W-1:0] paddr,
    input  logic [mtcg_pkg::PDATA_W-1:0] pwdata,
    output logic [mtcg_pkg::PDATA_W-1:0] prdata
);

    localparam int NIW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int ZIW = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
    localparam int SCW = NIW + 1;
    localparam int DCW = $clog2(mtcg_pkg::DIV_STEPS);
    localparam logic [SCW-1:0] SCAN_END = SCW'(NOTE_SLOTS);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(mtcg_pkg::DIV_STEPS - 1);
    localparam logic signed [7:0] ZONE_BASE = 8'(FIRST_ZONE);
    localparam logic signed [7:0] ZONE_CNT  = 8'(ZONE_SLOTS);

    mtcg_pkg::in_item_t item_reg, item_next;
    logic [6:0]  base_reg, base_next;
    logic [6:0]  tcc_reg, tcc_next;
    logic [15:0] gpt_reg, gpt_next;
    logic [15:0] rdt_reg, rdt_next;
    logic [6:0]  icp_reg, icp_next;

    logic [NOTE_SLOTS-1:0] flags_reg, flags_next;
    logic [6:0]  vmem [NOTE_SLOTS];
    logic [6:0]  vrd_reg;
    logic [7:0]  total_reg, total_next;
    logic        touch_reg, touch_next;
    logic        deb_run_reg, deb_run_next;
    logic [15:0] deb_cnt_reg, deb_cnt_next;
    logic signed [7:0] fast_reg, fast_next;
    logic signed [7:0] slow_reg, slow_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  pact_reg, pact_next;
    logic [15:0] pcnt_reg [3];
    logic [15:0] pcnt_next [3];
    logic        seen_reg, seen_next;
    logic signed [5:0] prev_reg, prev_next;
    logic [ZONE_SLOTS-1:0] zval_reg, zval_next;
    logic signed [7:0] zmem [ZONE_SLOTS];
    logic signed [7:0] zrd_reg;
    logic signed [7:0] zrel_reg, zrel_next;
    logic        zpulse_reg, zpulse_next;
    logic [6:0]  press_reg, press_next;
    logic [6:0]  peak_reg, peak_next;
    logic [13:0] num_reg, num_next;
    logic [6:0]  rem_reg, rem_next;
    logic [13:0] quo_reg, quo_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [SCW-1:0] scnt_reg, scnt_next;
    logic        pv_reg, pv_next;
    logic [NIW-1:0] pi_reg, pi_next;
    logic signed [7:0] top_reg, top_next;
    logic [6:0]  loud_reg, loud_next;
    mtcg_pkg::out_item_t out_reg, out_next;
    logic        ovalid_reg, ovalid_next;

    logic        wr_en;
    logic [2:0]  wr_idx;
    logic        key_ok;
    logic [NIW-1:0] kidx;
    logic        key_held;
    logic signed [7:0] rel;
    logic signed [7:0] zq;
    logic signed [7:0] zidx8;
    logic        zin_range;
    logic [ZIW-1:0] zidx;
    logic        zchanged;
    logic        zfirst;
    logic [NIW-1:0] sidx;
    logic        scan_live;
    logic [7:0]  rem_sh;
    logic        qbit;
    logic [6:0]  pk;
    logic [15:0] cinc;
    logic [15:0] dinc;

    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = paddr[4:2];

    assign key_ok   = ({1'b0, item_reg.key} < 8'(NOTE_SLOTS));
    assign kidx     = item_reg.key[NIW-1:0];
    assign key_held = key_ok && flags_reg[kidx];
    assign rel      = signed'({1'b0, item_reg.key}) - signed'({1'b0, base_reg});

    assign zq        = (zrel_reg < 0) ? ((zrel_reg + 8'sd3) >>> 2) : (zrel_reg >>> 2);
    assign zidx8     = zq - ZONE_BASE;
    assign zin_range = (zidx8 >= 0) && (zidx8 < ZONE_CNT);
    assign zidx      = zidx8[ZIW-1:0];
    assign zchanged  = seen_reg && (zq[5:0] != prev_reg);
    assign zfirst    = zchanged && zin_range && !zval_reg[zidx];

    assign scan_live = (scnt_reg < SCAN_END);
    assign sidx      = scnt_reg[NIW-1:0];

    assign rem_sh = {rem_reg, num_reg[13]};
    assign qbit   = (rem_sh >= {1'b0, peak_reg});
    assign pk     = (item_reg.amount > peak_reg) ? item_reg.amount : peak_reg;

    always_comb
    begin
        case (item_reg.cmd)
            mtcg_pkg::CMD_NOTE_ON:
            begin
                stat.kind    = (item_reg.amount != 7'd0) ? mtcg_pkg::KIND_PRESS
                                                         : mtcg_pkg::KIND_RELEASE;
                stat.item_ok = (item_reg.amount != 7'd0) ? (key_ok && !key_held) : key_held;
            end
            mtcg_pkg::CMD_NOTE_OFF:
            begin
                stat.kind    = mtcg_pkg::KIND_RELEASE;
                stat.item_ok = key_held;
            end
            mtcg_pkg::CMD_CC:
            begin
                stat.kind    = mtcg_pkg::KIND_CC;
                stat.item_ok = (item_reg.key == tcc_reg);
            end
            default:
            begin
                stat.kind    = mtcg_pkg::KIND_TICK;
                stat.item_ok = 1'b1;
            end
        endcase
        stat.press_zone     = touch_reg || (total_reg == 8'd0);
        stat.rel_scan       = touch_reg && (total_reg > 8'd1);
        stat.scan_done      = !scan_live;
        stat.div_done       = (dcnt_reg == DIV_LAST);
        stat.zone_need_read = zchanged && zin_range && zval_reg[zidx];
        stat.out_free       = !ovalid_reg || out_ready;
    end

    always_comb
    begin
        item_next    = ctrl.ld_item ? in_item : item_reg;
        base_next    = base_reg;
        tcc_next     = tcc_reg;
        gpt_next     = gpt_reg;
        rdt_next     = rdt_reg;
        icp_next     = icp_reg;
        flags_next   = flags_reg;
        total_next   = total_reg;
        touch_next   = touch_reg;
        deb_run_next = deb_run_reg;
        deb_cnt_next = deb_cnt_reg;
        fast_next    = fast_reg;
        slow_next    = slow_reg;
        rnd_next     = rnd_reg;
        pact_next    = pact_reg;
        pcnt_next    = pcnt_reg;
        seen_next    = seen_reg;
        prev_next    = prev_reg;
        zval_next    = zval_reg;
        zrel_next    = zrel_reg;
        zpulse_next  = zpulse_reg;
        press_next   = press_reg;
        peak_next    = peak_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        scnt_next    = scnt_reg;
        pv_next      = pv_reg;
        pi_next      = pi_reg;
        top_next     = top_reg;
        loud_next    = loud_reg;
        cinc         = 16'd0;
        dinc         = 16'd0;

        if (wr_en)
        begin
            case (wr_idx)
                mtcg_pkg::REG_BASE_NOTE:   base_next = pwdata[6:0];
                mtcg_pkg::REG_TOUCH_CC:    tcc_next  = pwdata[6:0];
                mtcg_pkg::REG_PULSE_TICKS: gpt_next  = pwdata[15:0];
                mtcg_pkg::REG_DEBOUNCE:    rdt_next  = pwdata[15:0];
                mtcg_pkg::REG_CC_PEAK:
                begin
                    icp_next  = pwdata[6:0];
                    peak_next = pwdata[6:0];
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
        end

        if (ctrl.do_press)
        begin
            flags_next[kidx] = 1'b1;
            if (total_reg < mtcg_pkg::TOTAL_MAX)
            begin
                total_next = total_reg + 8'd1;
            end
            deb_run_next = 1'b0;
            if ((total_reg == 8'd0) && !touch_reg)
            begin
                touch_next = 1'b1;
                seen_next  = 1'b0;
                prev_next  = 6'sd0;
                zval_next  = '0;
            end
            if (touch_reg || (total_reg == 8'd0))
            begin
                fast_next                       = rel;
                pact_next[mtcg_pkg::PULSE_FAST] = 1'b1;
                pcnt_next[mtcg_pkg::PULSE_FAST] = 16'd0;
                rnd_next                        = item_reg.amount;
                pact_next[mtcg_pkg::PULSE_RAND] = 1'b1;
                pcnt_next[mtcg_pkg::PULSE_RAND] = 16'd0;
                zrel_next                       = rel;
                zpulse_next                     = 1'b1;
            end
        end

        if (ctrl.do_release)
        begin
            flags_next[kidx] = 1'b0;
            scnt_next        = '0;
            pv_next          = 1'b0;
            top_next         = 8'sd0;
            loud_next        = 7'd0;
            if (total_reg != 8'd0)
            begin
                total_next = total_reg - 8'd1;
                if (touch_reg && (total_reg == 8'd1))
                begin
                    deb_run_next = 1'b1;
                    deb_cnt_next = 16'd0;
                end
            end
        end

        if (ctrl.scan_step)
        begin
            pv_next = scan_live && flags_reg[sidx];
            pi_next = sidx;
            if (scan_live)
            begin
                scnt_next = scnt_reg + SCW'(1);
            end
            if (pv_reg)
            begin
                top_next = signed'(8'(pi_reg)) - signed'({1'b0, base_reg});
                if (vrd_reg >= loud_reg)
                begin
                    loud_next = vrd_reg;
                end
            end
        end

        if (ctrl.scan_apply)
        begin
            fast_next   = top_reg;
            rnd_next    = loud_reg;
            zrel_next   = top_reg;
            zpulse_next = 1'b0;
        end

        if (ctrl.zone_eval)
        begin
            if (zchanged && !(zin_range && zval_reg[zidx]))
            begin
                slow_next = zrel_reg;
                if (zpulse_reg)
                begin
                    pact_next[mtcg_pkg::PULSE_SLOW] = 1'b1;
                    pcnt_next[mtcg_pkg::PULSE_SLOW] = 16'd0;
                end
            end
            if (zfirst)
            begin
                zval_next[zidx] = 1'b1;
            end
            prev_next = zq[5:0];
            seen_next = 1'b1;
        end

        if (ctrl.zone_read)
        begin
            slow_next = zrd_reg;
            if (zpulse_reg)
            begin
                pact_next[mtcg_pkg::PULSE_SLOW] = 1'b1;
                pcnt_next[mtcg_pkg::PULSE_SLOW] = 16'd0;
            end
        end

        if (ctrl.cc_start)
        begin
            peak_next = pk;
            num_next  = (14'(item_reg.amount) * 14'(mtcg_pkg::LEVEL_MAX)) + 14'(pk >> 1);
            rem_next  = 7'd0;
            quo_next  = 14'd0;
            dcnt_next = '0;
        end

        if (ctrl.div_step)
        begin
            rem_next  = qbit ? 7'(rem_sh - {1'b0, peak_reg}) : rem_sh[6:0];
            quo_next  = {quo_reg[12:0], qbit};
            num_next  = {num_reg[12:0], 1'b0};
            dcnt_next = dcnt_reg + DCW'(1);
        end

        if (ctrl.cc_end)
        begin
            if (peak_reg == 7'd0)
            begin
                press_next = 7'd0;
            end
            else if (quo_reg > 14'(mtcg_pkg::LEVEL_MAX))
            begin
                press_next = mtcg_pkg::LEVEL_MAX;
            end
            else
            begin
                press_next = quo_reg[6:0];
            end
        end

        if (ctrl.do_tick)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (pact_reg[k])
                begin
                    cinc = (pcnt_reg[k] < mtcg_pkg::TICKS_MAX) ? pcnt_reg[k] + 16'd1
                                                               : pcnt_reg[k];
                    pcnt_next[k] = cinc;
                    if (cinc >= gpt_reg)
                    begin
                        pact_next[k] = 1'b0;
                    end
                end
            end
            if ((total_reg == 8'd0) && touch_reg && deb_run_reg)
            begin
                dinc = (deb_cnt_reg < mtcg_pkg::TICKS_MAX) ? deb_cnt_reg + 16'd1
                                                           : deb_cnt_reg;
                deb_cnt_next = dinc;
                if (dinc >= rdt_reg)
                begin
                    touch_next   = 1'b0;
                    deb_run_next = 1'b0;
                    deb_cnt_next = 16'd0;
                    pact_next    = 3'b000;
                    seen_next    = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_next              = out_reg;
        ovalid_next           = ovalid_reg & ~out_ready;
        if (ctrl.out_load)
        begin
            out_next.fast_pitch   = mtcg_pkg::clamp_pitch(fast_reg);
            out_next.slow_pitch   = mtcg_pkg::clamp_pitch(slow_reg);
            out_next.random_level = rnd_reg;
            out_next.touch_level  = touch_reg ? press_reg : 7'd0;
            out_next.fast_gate    = pact_reg[mtcg_pkg::PULSE_FAST];
            out_next.slow_gate    = pact_reg[mtcg_pkg::PULSE_SLOW];
            out_next.random_gate  = pact_reg[mtcg_pkg::PULSE_RAND];
            out_next.touch_gate   = touch_reg;
            ovalid_next           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= mtcg_pkg::BASE_NOTE_RST;
            tcc_reg     <= mtcg_pkg::TOUCH_CC_RST;
            gpt_reg     <= mtcg_pkg::PULSE_TICKS_RST;
            rdt_reg     <= mtcg_pkg::DEBOUNCE_RST;
            icp_reg     <= mtcg_pkg::CC_PEAK_RST;
            peak_reg    <= mtcg_pkg::CC_PEAK_RST;
            flags_reg   <= '0;
            total_reg   <= 8'd0;
            touch_reg   <= 1'b0;
            deb_run_reg <= 1'b0;
            deb_cnt_reg <= 16'd0;
            fast_reg    <= 8'sd0;
            slow_reg    <= 8'sd0;
            rnd_reg     <= 7'd0;
            pact_reg    <= 3'b000;
            for (int k = 0; k < 3; k++)
            begin
                pcnt_reg[k] <= 16'd0;
            end
            seen_reg    <= 1'b0;
            prev_reg    <= 6'sd0;
            zval_reg    <= '0;
            press_reg   <= 7'd0;
            dcnt_reg    <= '0;
            scnt_reg    <= '0;
            pv_reg      <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            base_reg    <= base_next;
            tcc_reg     <= tcc_next;
            gpt_reg     <= gpt_next;
            rdt_reg     <= rdt_next;
            icp_reg     <= icp_next;
            peak_reg    <= peak_next;
            flags_reg   <= flags_next;
            total_reg   <= total_next;
            touch_reg   <= touch_next;
            deb_run_reg <= deb_run_next;
            deb_cnt_reg <= deb_cnt_next;
            fast_reg    <= fast_next;
            slow_reg    <= slow_next;
            rnd_reg     <= rnd_next;
            pact_reg    <= pact_next;
            pcnt_reg    <= pcnt_next;
            seen_reg    <= seen_next;
            prev_reg    <= prev_next;
            zval_reg    <= zval_next;
            press_reg   <= press_next;
            dcnt_reg    <= dcnt_next;
            scnt_reg    <= scnt_next;
            pv_reg      <= pv_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        zrel_reg   <= zrel_next;
        zpulse_reg <= zpulse_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        pi_reg     <= pi_next;
        top_reg    <= top_next;
        loud_reg   <= loud_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.do_press)
        begin
            vmem[kidx] <= item_reg.amount;
        end
        vrd_reg <= vmem[sidx];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.zone_eval && zfirst)
        begin
            zmem[zidx] <= zrel_reg;
        end
        zrd_reg <= zmem[zidx];
    end

    always_comb
    begin
        case (paddr[4:2])
            mtcg_pkg::REG_BASE_NOTE:   prdata = 32'(base_reg);
            mtcg_pkg::REG_TOUCH_CC:    prdata = 32'(tcc_reg);
            mtcg_pkg::REG_PULSE_TICKS: prdata = 32'(gpt_reg);
            mtcg_pkg::REG_DEBOUNCE:    prdata = 32'(rdt_reg);
            mtcg_pkg::REG_CC_PEAK:     prdata = 32'(icp_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    assign out_valid = ovalid_reg;
    assign out_item  = out_reg;

    // Gates only pulse while the keyboard is touched.
    a_pulse_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
        !touch_reg |-> (pact_reg == 3'b000))
        else $error("gate pulse active with touch off");

    a_total_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(flags_reg) == int'(total_reg))
        else $error("held count disagrees with held flags");

    a_debounce_idle_keys: assert property (@(posedge clk) disable iff (!rst_n)
        deb_run_reg |-> (touch_reg && (total_reg == 8'd0)))
        else $error("debounce running with notes held or touch off");

endmodule

[tb/sv/midi_touch_to_cv_gate_top_test.sv]
`timescale 1ns / 100ps

module midi_touch_to_cv_gate_top_test;

    localparam int WATCHDOG_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    mtcg_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    mtcg_pkg::out_item_t out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [mtcg_pkg::PADDR_W-1:0] paddr = '0;
    logic [mtcg_pkg::PDATA_W-1:0] pwdata = '0;
    logic [mtcg_pkg::PDATA_W-1:0] prdata;
    logic pready;

    always #1 clk = ~clk;

    midi_touch_to_cv_gate_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow of the converter's configuration and state.
    logic [6:0] cfg_base;
    logic [6:0] cfg_cc;
    logic [15:0] cfg_pulse;
    logic [15:0] cfg_debounce;
    logic [6:0] cfg_peak;
    logic held [128];
    logic [6:0] held_vel [128];
    int held_count;
    logic touching;
    logic debouncing;
    int debounce_count;
    int fast_rel;
    int slow_rel;
    logic [6:0] rand_vel;
    logic gate_on [3];
    int gate_count [3];
    logic zone_known;
    int last_zone;
    int zone_pitch [32];
    logic zone_set [32];
    logic [6:0] pressure;
    logic [6:0] peak;

    mtcg_pkg::out_item_t cv_expected [$];
    int errors = 0;
    int idle_cycles = 0;
    int items_sent = 0;

    task automatic shadow_reset();
        cfg_base = mtcg_pkg::BASE_NOTE_RST;
        cfg_cc = mtcg_pkg::TOUCH_CC_RST;
        cfg_pulse = mtcg_pkg::PULSE_TICKS_RST;
        cfg_debounce = mtcg_pkg::DEBOUNCE_RST;
        cfg_peak = mtcg_pkg::CC_PEAK_RST;
        for (int i = 0; i < 128; i++)
        begin
            held[i] = 1'b0;
            held_vel[i] = '0;
        end
        held_count = 0;
        touching = 1'b0;
        debouncing = 1'b0;
        debounce_count = 0;
        fast_rel = 0;
        slow_rel = 0;
        rand_vel = '0;
        for (int k = 0; k < 3; k++)
        begin
            gate_on[k] = 1'b0;
            gate_count[k] = 0;
        end
        zone_known = 1'b0;
        last_zone = 0;
        for (int z = 0; z < 32; z++)
        begin
            zone_pitch[z] = 0;
            zone_set[z] = 1'b0;
        end
        pressure = '0;
        peak = mtcg_pkg::CC_PEAK_RST;
    endtask

    function automatic logic [5:0] to_cv(int p);
        if (p < 0)
        begin
            return 6'd0;
        end
        if (p > 60)
        begin
            return 6'd60;
        end
        return p[5:0];
    endfunction

    task automatic update_zone(int rel, logic pulse);
        int zone;
        int pitch;
        zone = rel / 4;
        if (zone_known && zone != last_zone)
        begin
            pitch = rel;
            if (zone - mtcg_pkg::FIRST_ZONE_DEF >= 0 && zone - mtcg_pkg::FIRST_ZONE_DEF < 32)
            begin
                if (!zone_set[zone - mtcg_pkg::FIRST_ZONE_DEF])
                begin
                    zone_pitch[zone - mtcg_pkg::FIRST_ZONE_DEF] = rel;
                    zone_set[zone - mtcg_pkg::FIRST_ZONE_DEF] = 1'b1;
                end
                pitch = zone_pitch[zone - mtcg_pkg::FIRST_ZONE_DEF];
            end
            slow_rel = pitch;
            if (pulse)
            begin
                gate_on[mtcg_pkg::PULSE_SLOW] = 1'b1;
                gate_count[mtcg_pkg::PULSE_SLOW] = 0;
            end
        end
        last_zone = zone;
        zone_known = 1'b1;
    endtask

    task automatic release_note(int key);
        int top;
        int loud;
        if (!held[key])
        begin
            return;
        end
        held[key] = 1'b0;
        held_vel[key] = '0;
        if (held_count == 0)
        begin
            return;
        end
        held_count--;
        if (touching && held_count != 0)
        begin
            top = 0;
            loud = 0;
            for (int i = 0; i < 128; i++)
            begin
                if (held[i])
                begin
                    top = i - cfg_base;
                    if (held_vel[i] >= loud)
                    begin
                        loud = held_vel[i];
                    end
                end
            end
            fast_rel = top;
            update_zone(top, 1'b0);
            rand_vel = loud[6:0];
        end
        if (held_count == 0 && touching)
        begin
            debouncing = 1'b1;
            debounce_count = 0;
        end
    endtask

    task automatic press_note(int key, logic [6:0] vel);
        int rel;
        logic none_held;
        rel = key - cfg_base;
        if (held[key])
        begin
            return;
        end
        none_held = (held_count == 0);
        held[key] = 1'b1;
        held_vel[key] = vel;
        if (held_count < 255)
        begin
            held_count++;
        end
        debouncing = 1'b0;
        if (none_held && !touching)
        begin
            touching = 1'b1;
            zone_known = 1'b0;
            last_zone = 0;
            for (int z = 0; z < 32; z++)
            begin
                zone_pitch[z] = 0;
                zone_set[z] = 1'b0;
            end
        end
        if (touching)
        begin
            fast_rel = rel;
            gate_on[mtcg_pkg::PULSE_FAST] = 1'b1;
            gate_count[mtcg_pkg::PULSE_FAST] = 0;
            rand_vel = vel;
            gate_on[mtcg_pkg::PULSE_RAND] = 1'b1;
            gate_count[mtcg_pkg::PULSE_RAND] = 0;
            update_zone(rel, 1'b1);
        end
    endtask

    task automatic count_tick();
        for (int k = 0; k < 3; k++)
        begin
            if (gate_on[k])
            begin
                if (gate_count[k] < 65535)
                begin
                    gate_count[k]++;
                end
                if (gate_count[k] >= cfg_pulse)
                begin
                    gate_on[k] = 1'b0;
                end
            end
        end
        if (held_count != 0 || !touching || !debouncing)
        begin
            return;
        end
        if (debounce_count < 65535)
        begin
            debounce_count++;
        end
        if (debounce_count >= cfg_debounce)
        begin
            touching = 1'b0;
            debouncing = 1'b0;
            debounce_count = 0;
            for (int k = 0; k < 3; k++)
            begin
                gate_on[k] = 1'b0;
            end
            zone_known = 1'b0;
        end
    endtask

    task automatic scale_pressure(logic [6:0] cc_num, logic [6:0] value);
        int q;
        if (cc_num != cfg_cc)
        begin
            return;
        end
        if (value > peak)
        begin
            peak = value;
        end
        if (peak == 0)
        begin
            q = 0;
        end
        else
        begin
            q = (value * 127 + peak / 2) / peak;
            if (q > 127)
            begin
                q = 127;
            end
        end
        pressure = q[6:0];
    endtask

    task automatic predict_cv(mtcg_pkg::in_item_t it);
        mtcg_pkg::out_item_t r;
        case (mtcg_pkg::cmd_code_t'(it.cmd))
            mtcg_pkg::CMD_NOTE_ON:
            begin
                if (it.amount == 0)
                begin
                    release_note(it.key);
                end
                else
                begin
                    press_note(it.key, it.amount);
                end
            end
            mtcg_pkg::CMD_NOTE_OFF: release_note(it.key);
            mtcg_pkg::CMD_CC: scale_pressure(it.key, it.amount);
            default: count_tick();
        endcase
        r.fast_pitch = to_cv(fast_rel);
        r.slow_pitch = to_cv(slow_rel);
        r.random_level = rand_vel;
        r.touch_level = touching ? pressure : 7'd0;
        r.fast_gate = gate_on[mtcg_pkg::PULSE_FAST];
        r.slow_gate = gate_on[mtcg_pkg::PULSE_SLOW];
        r.random_gate = gate_on[mtcg_pkg::PULSE_RAND];
        r.touch_gate = touching;
        cv_expected.push_back(r);
    endtask

    // Sender bursts: a countdown of items before a gap.
    int burst_left = 0;

    task automatic send_event(mtcg_pkg::cmd_code_t c, int key, int amount);
        mtcg_pkg::in_item_t it;
        int gap;
        it.cmd = c;
        it.key = key[6:0];
        it.amount = amount[6:0];
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_cv(it);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (cv_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (mtcg_pkg::NOTE_SLOTS_DEF + 20) @(posedge clk);
    endtask

    task automatic write_reg(mtcg_pkg::reg_index_t idx, int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= mtcg_pkg::PADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mtcg_pkg::REG_BASE_NOTE: cfg_base = value[6:0];
            mtcg_pkg::REG_TOUCH_CC: cfg_cc = value[6:0];
            mtcg_pkg::REG_PULSE_TICKS: cfg_pulse = value[15:0];
            mtcg_pkg::REG_DEBOUNCE: cfg_debounce = value[15:0];
            default:
            begin
                cfg_peak = value[6:0];
                peak = value[6:0];
            end
        endcase
        @(posedge clk);
    endtask

    task automatic random_event(int note_lo, int note_hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            send_event(mtcg_pkg::CMD_NOTE_ON, $urandom_range(note_lo, note_hi),
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 127));
        end
        else if (r < 60)
        begin
            send_event(mtcg_pkg::CMD_NOTE_OFF, $urandom_range(note_lo, note_hi),
                $urandom_range(0, 127));
        end
        else if (r < 75)
        begin
            send_event(mtcg_pkg::CMD_CC,
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : cfg_cc,
                $urandom_range(0, 127));
        end
        else
        begin
            send_event(mtcg_pkg::CMD_TICK, $urandom_range(0, 127), $urandom_range(0, 127));
        end
    endtask

    task automatic test_directed();
        send_event(mtcg_pkg::CMD_CC, 1, 64);
        send_event(mtcg_pkg::CMD_NOTE_ON, 0, 1);
        send_event(mtcg_pkg::CMD_NOTE_ON, 127, 127);
        send_event(mtcg_pkg::CMD_NOTE_ON, 127, 50);
        send_event(mtcg_pkg::CMD_NOTE_ON, 60, 100);
        send_event(mtcg_pkg::CMD_NOTE_ON, 41, 30);
        send_event(mtcg_pkg::CMD_NOTE_OFF, 127, 0);
        send_event(mtcg_pkg::CMD_NOTE_ON, 60, 0);
        send_event(mtcg_pkg::CMD_NOTE_OFF, 99, 127);
        send_event(mtcg_pkg::CMD_CC, 1, 127);
        send_event(mtcg_pkg::CMD_CC, 5, 20);
        send_event(mtcg_pkg::CMD_NOTE_OFF, 0, 0);
        send_event(mtcg_pkg::CMD_NOTE_OFF, 41, 0);
        for (int i = 0; i < 60; i++)
        begin
            send_event(mtcg_pkg::CMD_TICK, 127, 127);
        end
    endtask

    task automatic test_config_extremes();
        write_reg(mtcg_pkg::REG_BASE_NOTE, 0);
        write_reg(mtcg_pkg::REG_TOUCH_CC, 127);
        write_reg(mtcg_pkg::REG_PULSE_TICKS, 0);
        write_reg(mtcg_pkg::REG_DEBOUNCE, 0);
        write_reg(mtcg_pkg::REG_CC_PEAK, 0);
        send_event(mtcg_pkg::CMD_CC, 127, 0);
        send_event(mtcg_pkg::CMD_NOTE_ON, 5, 9);
        send_event(mtcg_pkg::CMD_CC, 127, 33);
        send_event(mtcg_pkg::CMD_NOTE_OFF, 5, 0);
        send_event(mtcg_pkg::CMD_TICK, 0, 0);
        drain();
        write_reg(mtcg_pkg::REG_BASE_NOTE, 127);
        write_reg(mtcg_pkg::REG_PULSE_TICKS, 65535);
        write_reg(mtcg_pkg::REG_DEBOUNCE, 65535);
        write_reg(mtcg_pkg::REG_CC_PEAK, 127);
        for (int i = 0; i < 40; i++)
        begin
            random_event(0, 127);
        end
        drain();
    endtask

    task automatic test_random_playing();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(mtcg_pkg::REG_BASE_NOTE, $urandom_range(20, 60));
            write_reg(mtcg_pkg::REG_TOUCH_CC, $urandom_range(0, 127));
            write_reg(mtcg_pkg::REG_PULSE_TICKS, $urandom_range(0, 6));
            write_reg(mtcg_pkg::REG_DEBOUNCE, $urandom_range(0, 8));
            write_reg(mtcg_pkg::REG_CC_PEAK, $urandom_range(0, 127));
            for (int i = 0; i < 200; i++)
            begin
                if (i < 170)
                begin
                    random_event(cfg_base, cfg_base + 70 > 127 ? 127 : cfg_base + 70);
                end
                else
                begin
                    random_event(0, 127);
                end
            end
            drain();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= ($urandom_range(0, 3) != 0) || (items_sent % 100 > 70);
        end
    end

    always @(posedge clk)
    begin
        mtcg_pkg::out_item_t want;
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (cv_expected.size() == 0)
            begin
                $error("unexpected result %h", out_item);
                errors++;
            end
            else
            begin
                want = cv_expected.pop_front();
                if (out_item.fast_pitch !== want.fast_pitch)
                begin
                    $error("fast_pitch exp %0d got %0d", want.fast_pitch, out_item.fast_pitch);
                    errors++;
                end
                if (out_item.slow_pitch !== want.slow_pitch)
                begin
                    $error("slow_pitch exp %0d got %0d", want.slow_pitch, out_item.slow_pitch);
                    errors++;
                end
                if (out_item.random_level !== want.random_level)
                begin
                    $error("random_level exp %0d got %0d", want.random_level,
                        out_item.random_level);
                    errors++;
                end
                if (out_item.touch_level !== want.touch_level)
                begin
                    $error("touch_level exp %0d got %0d", want.touch_level,
                        out_item.touch_level);
                    errors++;
                end
                if (out_item.fast_gate !== want.fast_gate)
                begin
                    $error("fast_gate exp %0d got %0d", want.fast_gate, out_item.fast_gate);
                    errors++;
                end
                if (out_item.slow_gate !== want.slow_gate)
                begin
                    $error("slow_gate exp %0d got %0d", want.slow_gate, out_item.slow_gate);
                    errors++;
                end
                if (out_item.random_gate !== want.random_gate)
                begin
                    $error("random_gate exp %0d got %0d", want.random_gate,
                        out_item.random_gate);
                    errors++;
                end
                if (out_item.touch_gate !== want.touch_gate)
                begin
                    $error("touch_gate exp %0d got %0d", want.touch_gate, out_item.touch_gate);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        shadow_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain();
        test_config_extremes();
        test_random_playing();
        drain();
        if (errors == 0 && cv_expected.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[midi_touch_to_cv_gate_top.f]
rtl/core/mtcg_pkg.sv
rtl/core/mtcg_ctrl.sv
rtl/core/mtcg_dp.sv
rtl/core/midi_touch_to_cv_gate_top.sv
tb/sv/midi_touch_to_cv_gate_top_test.sv
